// ===== hdl/tbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared constants, codes and types for the touch baseline and debounce block.
// ----------------------------------------------------------------------------
package tbd_pkg;

    // channel count and calibration round length
    localparam int CHANNELS      = 4;
    localparam int SAMPLE_FIELDS = 4;
    localparam int CAL_SAMPLES   = 10;

    // field and state widths
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 16;
    localparam int CNT_W    = 8;
    localparam int SUM_W    = 20;
    localparam int PROG_W   = 4;
    localparam int CFG_W    = 16;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);
    localparam logic [CNT_W-1:0] DBC_RESET = CNT_W'(3);

    // saturation value of the debounce counter
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // round length in progress-counter width
    localparam logic [PROG_W-1:0] CAL_LAST = PROG_W'(CAL_SAMPLES);

    // reciprocal for sum / CAL_SAMPLES: quotient = (sum * DIV_MUL) >> DIV_SHIFT
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int DIV_MUL_W = DIV_SHIFT + 1;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam int PROD_W = SUM_W + DIV_MUL_W;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_DEBOUNCE  = 1'b1
    } t_cfg_idx;

    // scan commands
    typedef enum logic [0:0] {
        CMD_DETECT    = 1'b0,
        CMD_CALIBRATE = 1'b1
    } t_cmd;

    // per-scan control broadcast to every channel
    typedef struct packed {
        logic fire;         // scan is processed this cycle
        logic calibrate;    // calibration scan, else detection scan
        logic round_start;  // first calibration scan of a round
        logic round_done;   // last calibration scan of a round
    } t_scan_ctl;

endpackage

// ===== hdl/touch_baseline_debounce.sv =====
// ----------------------------------------------------------------------------
// touch_baseline_debounce
// Four-channel capacitive touch front end with calibrated baselines,
// threshold compare and debounce.
// ----------------------------------------------------------------------------
// path: channel update from the input register into the result register
// throughput: one scan per cycle while the result register is not stalled;
//   the channel update is single pass
// reset: synchronous active low; baselines, sums, counters and touch states
//   clear, threshold 1000, debounce count 3, no clearing pass
// ----------------------------------------------------------------------------
module touch_baseline_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [tbd_pkg::CFG_W-1:0]     i_cfg_data,
    // scan input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [tbd_pkg::SAMPLE_W-1:0]  i_sample_0,
    input  logic [tbd_pkg::SAMPLE_W-1:0]  i_sample_1,
    input  logic [tbd_pkg::SAMPLE_W-1:0]  i_sample_2,
    input  logic [tbd_pkg::SAMPLE_W-1:0]  i_sample_3,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_touch_mask,
    output logic                          o_baseline_ready
);

    // configuration registers
    logic [tbd_pkg::THR_W-1:0] r_threshold;
    logic [tbd_pkg::CNT_W-1:0] r_debounce;

    // input register
    logic                         r_in_valid;
    logic                         r_command;
    logic [tbd_pkg::SAMPLE_W-1:0] r_sample [tbd_pkg::SAMPLE_FIELDS];

    // round progress and ready flag
    logic [tbd_pkg::PROG_W-1:0] r_prog, n_prog, prog_inc;
    logic                       r_ready_flag, n_ready_flag;

    // result register
    logic       r_out_valid;
    logic [3:0] r_out_mask, n_out_mask;
    logic       r_out_ready;

    logic                         out_free;
    logic                         fire;
    tbd_pkg::t_scan_ctl           scan_ctl;
    logic [tbd_pkg::SAMPLE_W-1:0] ch_sample [tbd_pkg::CHANNELS];
    logic [tbd_pkg::CHANNELS-1:0] ch_state;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tbd_pkg::THR_RESET;
            r_debounce  <= tbd_pkg::DBC_RESET;
        end else if (i_cfg_we) begin
            case (tbd_pkg::t_cfg_idx'(i_cfg_idx))
                tbd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[tbd_pkg::THR_W-1:0];
                tbd_pkg::CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[tbd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: stage advances when the result register is free
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_command   <= i_command;
            r_sample[0] <= i_sample_0;
            r_sample[1] <= i_sample_1;
            r_sample[2] <= i_sample_2;
            r_sample[3] <= i_sample_3;
        end
    end

    // calibration round control
    assign prog_inc = r_prog + 1'b1;

    always_comb begin
        scan_ctl.fire        = fire;
        scan_ctl.calibrate   = fire && (tbd_pkg::t_cmd'(r_command) == tbd_pkg::CMD_CALIBRATE);
        scan_ctl.round_start = (r_prog == '0);
        scan_ctl.round_done  = (prog_inc >= tbd_pkg::CAL_LAST);
    end

    always_comb begin
        n_prog       = r_prog;
        n_ready_flag = r_ready_flag;
        if (scan_ctl.calibrate) begin
            if (scan_ctl.round_done) begin
                n_prog       = '0;
                n_ready_flag = 1'b1;
            end else begin
                n_prog = prog_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog       <= '0;
            r_ready_flag <= 1'b0;
        end else begin
            r_prog       <= n_prog;
            r_ready_flag <= n_ready_flag;
        end
    end

    // channels; one without a sample field reads zero
    for (genvar g = 0; g < tbd_pkg::CHANNELS; g++) begin : g_ch
        if (g < tbd_pkg::SAMPLE_FIELDS) begin : g_fed
            assign ch_sample[g] = r_sample[g];
        end else begin : g_unfed
            assign ch_sample[g] = '0;
        end

        tbd_channel u_channel (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (scan_ctl),
            .i_sample     (ch_sample[g]),
            .i_threshold  (r_threshold),
            .i_debounce   (r_debounce),
            .o_next_state (ch_state[g])
        );
    end

    // mask of the first four channels
    always_comb begin
        n_out_mask = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < tbd_pkg::CHANNELS) begin
                n_out_mask[i] = ch_state[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_mask  <= n_out_mask;
            r_out_ready <= n_ready_flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_touch_mask     = r_out_mask;
    assign o_baseline_ready = r_out_ready;

endmodule

// ===== hdl/tbd_channel.sv =====
// ----------------------------------------------------------------------------
// tbd_channel
// One touch channel: calibration sum, baseline, threshold compare, debounce
// counter and debounced touch state.
// ----------------------------------------------------------------------------
module tbd_channel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbd_pkg::t_scan_ctl            i_ctl,
    input  logic [tbd_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [tbd_pkg::THR_W-1:0]     i_threshold,
    input  logic [tbd_pkg::CNT_W-1:0]     i_debounce,
    output logic                          o_next_state
);

    logic [tbd_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [tbd_pkg::SAMPLE_W-1:0] r_baseline, n_baseline;
    logic [tbd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         r_state, n_state;

    logic [tbd_pkg::SUM_W-1:0]    sum_base;
    logic [tbd_pkg::SUM_W-1:0]    sum_add;
    logic [tbd_pkg::PROD_W-1:0]   quot_prod;
    logic [tbd_pkg::THR_W:0]      limit;
    logic                         raw_touch;
    logic [tbd_pkg::CNT_W-1:0]    cnt_inc;

    // running sum, restarted on the first scan of a round
    assign sum_base = i_ctl.round_start ? '0 : r_sum;
    assign sum_add  = sum_base + tbd_pkg::SUM_W'(i_sample);

    // sum divided by the round length through the reciprocal
    assign quot_prod = tbd_pkg::PROD_W'(sum_add) * tbd_pkg::PROD_W'(tbd_pkg::DIV_MUL);

    // threshold compare at one bit more than the baseline
    assign limit     = (tbd_pkg::THR_W+1)'(r_baseline) + (tbd_pkg::THR_W+1)'(i_threshold);
    assign raw_touch = (tbd_pkg::THR_W+1)'(i_sample) > limit;
    assign cnt_inc   = (r_cnt == tbd_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;

    // next state of the channel
    always_comb begin
        n_sum      = r_sum;
        n_baseline = r_baseline;
        n_cnt      = r_cnt;
        n_state    = r_state;
        if (i_ctl.calibrate) begin
            if (i_ctl.round_start) begin
                n_cnt   = '0;
                n_state = 1'b0;
            end
            if (i_ctl.round_done) begin
                n_baseline = quot_prod[tbd_pkg::DIV_SHIFT +: tbd_pkg::SAMPLE_W];
                n_sum      = '0;
            end else begin
                n_sum = sum_add;
            end
        end else if (raw_touch != r_state) begin
            if (cnt_inc >= i_debounce) begin
                n_state = raw_touch;
                n_cnt   = '0;
            end else begin
                n_cnt = cnt_inc;
            end
        end else begin
            n_cnt = '0;
        end
    end

    // channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_baseline <= '0;
            r_cnt      <= '0;
            r_state    <= 1'b0;
        end else if (i_ctl.fire) begin
            r_sum      <= n_sum;
            r_baseline <= n_baseline;
            r_cnt      <= n_cnt;
            r_state    <= n_state;
        end
    end

    assign o_next_state = i_ctl.fire ? n_state : r_state;

endmodule

// ===== hdl/tbd_checker.sv =====
// ----------------------------------------------------------------------------
// tbd_checker
// Port-level checks for the touch baseline and debounce block.
// ----------------------------------------------------------------------------
module tbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_touch_mask,
    input logic       o_baseline_ready
);

    // remembers that a delivered result already showed a finished round
    logic r_seen_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_baseline_ready) begin
            r_seen_ready <= 1'b1;
        end
    end

    // result stays offered until the transaction completes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_touch_mask) && $stable(o_baseline_ready))
        else $error("stalled result changed");

    // once a round has completed, every later result reports ready
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_ready |-> o_baseline_ready)
        else $error("baseline ready flag fell");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind touch_baseline_debounce tbd_checker u_tbd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_touch_mask     (o_touch_mask),
    .o_baseline_ready (o_baseline_ready)
);
